// File: hw/rtl/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg: shared types and constants of the run-length pixel decoder
// Beat payloads, the front-to-back command and the register map.
// ----------------------------------------------------------------------------
`default_nettype none

package trd_pkg;

  // Longest packet that one header can announce
  localparam int unsigned MaxPacketPixels = 128;
  localparam int unsigned PktCntW         = $clog2(MaxPacketPixels + 1);

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned BppW     = 3;
  localparam int unsigned PixW     = 32;

  localparam logic [BppW-1:0] BppReset   = 3'd3;
  localparam logic [PixW-1:0] TotalReset = 32'd1;

  // Depth of the command queue between front and back
  localparam int unsigned QueueDepthDefault = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BPP   = 1'b0,
    REG_TOTAL = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    PH_HEADER = 1'b0,
    PH_PIXEL  = 1'b1
  } phase_e;

  // Input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       image_start;
  } trd_in_t;

  // Output beat
  typedef struct packed {
    logic [PixW-1:0] pixel_first;
    logic [PixW-1:0] pixel_second;
    logic [1:0]      pixel_count;
    logic            last_of_item;
    logic            image_done;
    logic            overrun;
  } trd_out_t;

  // One decoded pixel and how many times to repeat it
  typedef struct packed {
    logic [PixW-1:0]    pixel;
    logic [PktCntW-1:0] npix;
    logic               clipped;
    logic               done_at_end;
  } trd_cmd_t;

  // Queue status toward its neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } trd_qstat_t;

endpackage

`default_nettype wire

// File: hw/rtl/trd_stream_if.sv
// ----------------------------------------------------------------------------
// trd_stream_if: valid/ready stream channel
// Carries one payload beat per handshake; source drives, sink accepts.
// ----------------------------------------------------------------------------
`default_nettype none

interface trd_stream_if #(
  parameter type data_t = logic
);

  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// File: hw/rtl/tga_rle_pixel_decoder_core.sv
// Path: a completed pixel reaches the output through the command queue
//   write, then the output register.
// Throughput: one input byte per cycle; a run of n pixels drains as ceil(n/2)
//   beats, one per cycle while the sink is ready, and input stalls once the command queue fills.
// Reset: asynchronous, active low; registers return to 3 bytes per pixel
//   and a total of 1 pixel, decoder waits for a packet header.
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_core: run-length image pixel stream decoder
// Parser front, command queue and run expander back with config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder_core #(
  parameter int unsigned QueueDepth = trd_pkg::QueueDepthDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  trd_stream_if.sink                          in_i,
  trd_stream_if.source                        out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [trd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [trd_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import trd_pkg::*;

  logic [BppW-1:0] bpp_q;
  logic [PixW-1:0] total_q;

  trd_in_t    in_data;
  trd_out_t   out_data;
  trd_cmd_t   push_data;
  trd_cmd_t   head;
  trd_qstat_t qstat;
  logic       push;
  logic       pop;
  logic       in_ready;
  logic       out_valid;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q   <= BppReset;
      total_q <= TotalReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BPP:   bpp_q   <= cfg_wdata_i[BppW-1:0];
        REG_TOTAL: total_q <= cfg_wdata_i[PixW-1:0];
        default: ;
      endcase
    end
  end

  assign in_data     = in_i.data;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

  trd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_data_i   (in_data),
    .in_ready_o  (in_ready),
    .bpp_i       (bpp_q),
    .total_i     (total_q),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  trd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (qstat)
  );

  trd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_ready_i (out_o.ready)
  );

`ifndef SYNTHESIS
  // A single-pixel beat never carries a second pixel
  a_single_second_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.pixel_count == 2'd1 |-> out_data.pixel_second == '0)
    else $error("single-pixel beat with nonzero second pixel");

  // Image completion is only flagged on the closing beat of a command
  a_done_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.image_done |-> out_data.last_of_item)
    else $error("image_done on a beat that is not last_of_item");

  // The parser never writes into a full queue
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("command pushed into a full queue");

  // The expander only pops a queue that holds a command
  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("command popped from an empty queue");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/trd_queue.sv
// ----------------------------------------------------------------------------
// trd_queue: small command queue
// Register-based FIFO that decouples the byte parser from the expander.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_queue #(
  parameter int unsigned Depth = trd_pkg::QueueDepthDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire trd_pkg::trd_cmd_t push_data_i,
  input  wire logic              pop_i,
  output trd_pkg::trd_cmd_t      head_o,
  output trd_pkg::trd_qstat_t    stat_o
);
  import trd_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  trd_cmd_t         mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

// File: hw/rtl/trd_front.sv
// ----------------------------------------------------------------------------
// trd_front: packet parser
// Takes one stream byte per beat, tracks packet headers, gathers pixel bytes
// and issues one repeat command per finished pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire trd_pkg::trd_in_t             in_data_i,
  output logic                              in_ready_o,
  input  wire logic [trd_pkg::BppW-1:0]     bpp_i,
  input  wire logic [trd_pkg::PixW-1:0]     total_i,
  input  wire trd_pkg::trd_qstat_t          qstat_i,
  output logic                              push_o,
  output trd_pkg::trd_cmd_t                 push_data_o
);
  import trd_pkg::*;

  phase_e             phase_q, phase_d;
  logic [PktCntW-1:0] left_q, left_d;
  logic               run_q, run_d;
  logic [1:0]         idx_q, idx_d;
  logic [PixW-1:0]    gather_q, gather_d;
  logic [PixW-1:0]    done_q, done_d;
  logic               clip_q, clip_d;

  logic               accept;
  logic [BppW-1:0]    bpp_eff;
  phase_e             phase_eff;
  logic [PixW-1:0]    done_eff;
  logic [PixW-1:0]    remain;
  logic [PktCntW-1:0] hdr_cnt;
  logic [PixW-1:0]    gather_new;
  logic [PktCntW-1:0] emit_n;
  logic [PixW-1:0]    done_new;

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // Pixel size clamped to 1..4
  always_comb begin
    bpp_eff = bpp_i;
    if (bpp_i == '0) begin
      bpp_eff = BppW'(1);
    end else if (bpp_i > BppW'(4)) begin
      bpp_eff = BppW'(4);
    end
  end

  // Image start clears the state before the byte is looked at
  assign phase_eff = in_data_i.image_start ? PH_HEADER : phase_q;
  assign done_eff  = in_data_i.image_start ? '0 : done_q;

  assign remain     = total_i - done_eff;
  assign hdr_cnt    = PktCntW'({1'b0, in_data_i.data_byte[6:0]}) + 1'b1;
  assign gather_new = gather_q | (PixW'(in_data_i.data_byte) << {idx_q, 3'b000});
  assign emit_n     = run_q ? left_q : PktCntW'(1);
  assign done_new   = done_q + PixW'(emit_n);

  // Next state and command issue
  always_comb begin
    phase_d     = phase_q;
    left_d      = left_q;
    run_d       = run_q;
    idx_d       = idx_q;
    gather_d    = gather_q;
    done_d      = done_q;
    clip_d      = clip_q;
    push_o      = 1'b0;
    push_data_o = '{pixel: gather_new, npix: emit_n, clipped: clip_q,
                    done_at_end: (done_new >= total_i)};

    if (accept) begin
      if (in_data_i.image_start) begin
        phase_d  = PH_HEADER;
        left_d   = '0;
        run_d    = 1'b0;
        idx_d    = '0;
        gather_d = '0;
        done_d   = '0;
        clip_d   = 1'b0;
      end
      if (done_eff < total_i) begin
        case (phase_eff)
          PH_HEADER: begin
            run_d    = in_data_i.data_byte[7];
            idx_d    = '0;
            gather_d = '0;
            phase_d  = PH_PIXEL;
            if (PixW'(hdr_cnt) > remain) begin
              left_d = remain[PktCntW-1:0];
              clip_d = 1'b1;
            end else begin
              left_d = hdr_cnt;
              clip_d = 1'b0;
            end
          end
          PH_PIXEL: begin
            if (BppW'({1'b0, idx_q}) + 1'b1 < bpp_eff) begin
              idx_d    = idx_q + 1'b1;
              gather_d = gather_new;
            end else begin
              // pixel complete: hand it to the expander
              push_o   = 1'b1;
              left_d   = run_q ? '0 : left_q - 1'b1;
              done_d   = done_new;
              idx_d    = '0;
              gather_d = '0;
              if ((run_q ? '0 : left_q - 1'b1) == '0) begin
                phase_d = PH_HEADER;
              end
            end
          end
          default: phase_d = PH_HEADER;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      left_q   <= '0;
      run_q    <= 1'b0;
      idx_q    <= '0;
      gather_q <= '0;
      done_q   <= '0;
      clip_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      run_q    <= run_d;
      idx_q    <= idx_d;
      gather_q <= gather_d;
      done_q   <= done_d;
      clip_q   <= clip_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/trd_back.sv
// ----------------------------------------------------------------------------
// trd_back: run expander
// Turns each queued command into output beats of up to two pixels, one beat
// per cycle while the sink accepts, behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire trd_pkg::trd_cmd_t   head_i,
  input  wire trd_pkg::trd_qstat_t qstat_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  output trd_pkg::trd_out_t        out_data_o,
  input  wire logic                out_ready_i
);
  import trd_pkg::*;

  logic               started_q, started_d;
  logic [PktCntW-1:0] left_q, left_d;
  logic               valid_q, valid_d;
  trd_out_t           data_q, data_d;

  logic [PktCntW-1:0] rem;
  logic               two;
  logic               last;
  logic               emit;

  // Pixels still owed for the head command
  assign rem  = started_q ? left_q : head_i.npix;
  assign two  = (rem >= PktCntW'(2));
  assign last = (rem <= PktCntW'(2));
  assign emit = !qstat_i.empty && (!valid_q || out_ready_i);

  always_comb begin
    started_d = started_q;
    left_d    = left_q;
    valid_d   = valid_q;
    data_d    = data_q;
    pop_o     = 1'b0;
    if (valid_q && out_ready_i) begin
      valid_d = 1'b0;
    end
    if (emit) begin
      valid_d = 1'b1;
      data_d  = '{pixel_first:  head_i.pixel,
                  pixel_second: two ? head_i.pixel : '0,
                  pixel_count:  two ? 2'd2 : 2'd1,
                  last_of_item: last,
                  image_done:   last && head_i.done_at_end,
                  overrun:      head_i.clipped};
      if (last) begin
        pop_o     = 1'b1;
        started_d = 1'b0;
      end else begin
        started_d = 1'b1;
        left_d    = rem - PktCntW'(2);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      left_q    <= '0;
      valid_q   <= 1'b0;
    end else begin
      started_q <= started_d;
      left_q    <= left_d;
      valid_q   <= valid_d;
    end
  end

  // Output payload, no reset needed
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// File: dv/tga_rle_pixel_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_checker: scoreboard for the run-length pixel decoder
// Follows the register port and the byte channel, decodes the stream on its
// own and compares every pixel beat, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_checker
  import trd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  trd_in_t             in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  trd_out_t            out_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int unsigned         beats_due_o,
  output int unsigned         fail_count_o
);

  // Register copies
  logic [BppW-1:0] bpp_reg;
  logic [PixW-1:0] total_reg;

  // Parser state
  phase_e          phase;
  logic [7:0]      pkt_left;
  logic            run_pkt;
  logic [1:0]      byte_idx;
  logic [PixW-1:0] gather;
  logic [31:0]     pixels_made;
  logic            clipped;

  trd_out_t        pixel_beats_due[$];
  trd_out_t        want;
  int unsigned     beat_no;

  task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] got_val);
    $display("[%0t] pixel beat %0d: %s expected %h got %h",
             $realtime, beat_no, what, exp_val, got_val);
    fail_count_o++;
  endtask

  // New image: parser back to header, pixel count cleared
  function automatic void clear_image();
    phase       = PH_HEADER;
    pkt_left    = '0;
    run_pkt     = 1'b0;
    byte_idx    = '0;
    gather      = '0;
    pixels_made = '0;
    clipped     = 1'b0;
  endfunction

  function automatic void push_beat(input logic [PixW-1:0] p1, input logic [PixW-1:0] p2,
                                    input logic [1:0] cnt);
    trd_out_t b;
    b.pixel_first  = p1;
    b.pixel_second = p2;
    b.pixel_count  = cnt;
    b.last_of_item = 1'b0;
    b.image_done   = (pixels_made >= total_reg);
    b.overrun      = clipped;
    pixel_beats_due.push_back(b);
  endfunction

  // Decode one accepted byte and queue the pixel beats it releases
  task automatic decode_byte(input trd_in_t beat);
    int unsigned eff_bpp, npix, room, step, first_new;
    first_new = pixel_beats_due.size();
    if (beat.image_start) clear_image();
    if (pixels_made >= total_reg) return;
    eff_bpp = (bpp_reg == 0) ? 1 : (bpp_reg > 4) ? 4 : bpp_reg;

    // header: pick packet kind, clip to the pixels still missing
    if (phase == PH_HEADER) begin
      npix    = beat.data_byte[6:0] + 1;
      room    = total_reg - pixels_made;
      run_pkt = beat.data_byte[7];
      clipped = (npix > room);
      if (clipped) npix = room;
      pkt_left = npix[7:0];
      byte_idx = '0;
      gather   = '0;
      phase    = PH_PIXEL;
      return;
    end

    gather |= PixW'(beat.data_byte) << (8 * byte_idx);
    if (byte_idx + 1 < eff_bpp) begin
      byte_idx++;
      return;
    end

    // pixel complete: whole run in pairs, or one literal
    if (run_pkt) begin
      while (pkt_left > 0) begin
        step = (pkt_left >= 2) ? 2 : 1;
        pkt_left    -= step;
        pixels_made += step;
        push_beat(gather, (step == 2) ? gather : '0, 2'(step));
      end
    end else begin
      if (pkt_left > 0) pkt_left--;
      pixels_made++;
      push_beat(gather, '0, 2'd1);
    end
    byte_idx = '0;
    gather   = '0;
    if (pkt_left == 0) phase = PH_HEADER;
    if (pixel_beats_due.size() > first_new)
      pixel_beats_due[pixel_beats_due.size() - 1].last_of_item = 1'b1;
  endtask

  // Output compare first: a beat never stems from a byte taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_reg   = BppReset;
      total_reg = TotalReset;
      clear_image();
      pixel_beats_due.delete();
      beat_no      = 0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pixel_beats_due.size() == 0) begin
          report_mismatch("beat with none due, pixel_first", '0, out_data_i.pixel_first);
        end else begin
          want = pixel_beats_due.pop_front();
          if (out_data_i.pixel_first !== want.pixel_first)
            report_mismatch("pixel_first", want.pixel_first, out_data_i.pixel_first);
          if (out_data_i.pixel_second !== want.pixel_second)
            report_mismatch("pixel_second", want.pixel_second, out_data_i.pixel_second);
          if (out_data_i.pixel_count !== want.pixel_count)
            report_mismatch("pixel_count", want.pixel_count, out_data_i.pixel_count);
          if (out_data_i.last_of_item !== want.last_of_item)
            report_mismatch("last_of_item", want.last_of_item, out_data_i.last_of_item);
          if (out_data_i.image_done !== want.image_done)
            report_mismatch("image_done", want.image_done, out_data_i.image_done);
          if (out_data_i.overrun !== want.overrun)
            report_mismatch("overrun", want.overrun, out_data_i.overrun);
        end
        beat_no++;
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_BPP:   bpp_reg = cfg_wdata_i[BppW-1:0];
          REG_TOTAL: total_reg = cfg_wdata_i[PixW-1:0];
          default:   ;
        endcase
      end
      if (in_valid_i && in_ready_i) decode_byte(in_data_i);
    end
    beats_due_o = pixel_beats_due.size();
  end

endmodule

// File: dv/tga_rle_pixel_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_core_tb: stimulus and verdict for the pixel decoder
// Directed packets for the corner cases, then random images under random
// idling on both channels and one long output hold-off; the scoreboard
// beside the decoder does all the checking.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_core_tb;
  import trd_pkg::*;

  localparam int unsigned RandBytes   = 225;
  localparam int unsigned CycleLimit  = 800_000;
  localparam int unsigned DrainCycles = 8;
  localparam logic [31:0] TotalMax    = 32'd4294836225;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  int unsigned beats_due, fail_count, cycle_count;
  int unsigned bytes_sent, bytes_ignored, rx_hold_cycles;
  bit          tx_gaps, rx_gaps;

  trd_stream_if #(.data_t(trd_in_t))  in_if ();
  trd_stream_if #(.data_t(trd_out_t)) out_if ();

  tga_rle_pixel_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  tga_rle_pixel_decoder_checker u_scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_ready_i   (in_if.ready),
    .in_data_i    (in_if.data),
    .out_valid_i  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_data_i   (out_if.data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .beats_due_o  (beats_due),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Pixel sink: random stall per beat, or a long hold when asked for
  initial begin : pixel_sink
    int unsigned stall;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rx_hold_cycles;
      rx_hold_cycles = 0;
      if (stall == 0 && rx_gaps) stall = $urandom_range(0, 6);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  // One byte beat; valid stays up into the next beat when there is no gap
  task automatic send_byte(input logic [7:0] value, input logic new_image);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{data_byte: value, image_start: new_image};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Stop sending and let every due pixel beat come out
  task automatic wait_pixels_out();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (beats_due != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [BppW-1:0] bpp, input logic [31:0] total);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_BPP;
    cfg_wdata <= CfgDataW'(bpp);
    @(posedge clk_i);
    cfg_idx   <= REG_TOTAL;
    cfg_wdata <= total;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Well-formed image with random packets; now and then a packet is cut short
  task automatic send_image(input int unsigned bpp_eff, input logic [31:0] total);
    logic [31:0] left;
    logic [7:0]  hdr;
    int unsigned npix, nbytes, packets;
    bit          new_image;
    left      = total;
    packets   = 0;
    new_image = 1'b1;
    while (left != 0 && packets < 8) begin
      if ($urandom_range(0, 9) == 0) hdr = 8'($urandom);
      else hdr = {1'($urandom), 7'($urandom_range(0, 7))};
      npix = hdr[6:0] + 1;
      if (npix > left) npix = left;
      nbytes = hdr[7] ? bpp_eff : npix * bpp_eff;
      send_byte(hdr, new_image);
      new_image = 1'b0;
      if ($urandom_range(0, 24) == 0) begin
        repeat ($urandom_range(0, nbytes - 1)) send_byte(8'($urandom), 1'b0);
        return;
      end
      repeat (nbytes) send_byte(8'($urandom), 1'b0);
      left -= npix;
      packets++;
    end
    // trailing byte past the pixel total is dropped by the decoder
    if (left == 0 && $urandom_range(0, 3) == 0) begin
      send_byte(8'($urandom), 1'b0);
      bytes_ignored++;
    end
  endtask

  initial begin : byte_source
    int unsigned     base, pick, eff;
    logic [BppW-1:0] bpp;
    logic [31:0]     total;

    in_if.valid    = 1'b0;
    in_if.data     = '0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_BPP;
    cfg_wdata      = '0;
    tx_gaps        = 1'b1;
    rx_gaps        = 1'b1;
    rx_hold_cycles = 0;
    bytes_sent     = 0;
    bytes_ignored  = 0;
    rst_ni         = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-byte pixels: raw of three, even run, odd run, then a dropped byte
    write_regs(3'd1, 32'd10);
    send_byte(8'h02, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h83, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h11, 1'b0);
    bytes_ignored++;
    wait_pixels_out();

    // longest run clipped to the total, four-byte pixels
    write_regs(3'd4, 32'd5);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    wait_pixels_out();

    // longest raw packet clipped
    write_regs(3'd2, 32'd2);
    send_byte(8'h7F, 1'b1);
    repeat (4) send_byte(8'($urandom), 1'b0);
    wait_pixels_out();

    // zero total: everything dropped; pixel size above range acts as four
    write_regs(3'd7, 32'd0);
    send_byte(8'h80, 1'b1);
    bytes_ignored++;
    wait_pixels_out();

    // pixel size zero acts as one
    write_regs(3'd0, 32'd3);
    send_byte(8'h00, 1'b1);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h3C, 1'b0);
    wait_pixels_out();

    // pixel size changed inside a raw packet, total 0xFFFE0001
    write_regs(3'd2, TotalMax);
    send_byte(8'h01, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    wait_pixels_out();
    write_regs(3'd3, TotalMax);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h9A, 1'b0);
    wait_pixels_out();

    // long sink hold while full runs keep coming: input must back up
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    write_regs(3'd1, 32'd600);
    rx_hold_cycles = 300;
    send_byte(8'hFF, 1'b1);
    send_byte(8'h3C, 1'b0);
    repeat (4) begin
      send_byte(8'hFF, 1'b0);
      send_byte(8'($urandom), 1'b0);
    end
    wait_pixels_out();

    // random images, with some noise bursts
    base = bytes_sent - bytes_ignored;
    while (bytes_sent - bytes_ignored - base < RandBytes) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      bpp = ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
      eff = (bpp == 0) ? 1 : (bpp > 4) ? 4 : bpp;
      pick = $urandom_range(0, 19);
      if (pick == 0) total = $urandom;
      else if (pick == 1) total = $urandom_range(100, 400);
      else if (pick == 2) total = 32'd1;
      else total = $urandom_range(2, 40);
      write_regs(bpp, total);
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(3, 10)) send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
      else
        send_image(eff, total);
      wait_pixels_out();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && beats_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/trd_pkg.sv
hw/rtl/trd_stream_if.sv
hw/rtl/trd_queue.sv
hw/rtl/trd_front.sv
hw/rtl/trd_back.sv
hw/rtl/tga_rle_pixel_decoder_core.sv
dv/tga_rle_pixel_decoder_checker.sv
dv/tga_rle_pixel_decoder_core_tb.sv
